[rtl/nadir_view_angle_pixel_unit_defines.svh]
// assertion macros shared by the nadir view angle rtl
// expects clk and rst in the scope where a macro is used
`ifndef NADIR_VIEW_ANGLE_PIXEL_UNIT_DEFINES_SVH
`define NADIR_VIEW_ANGLE_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication
`define NVAP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NVAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nvap_pkg.sv]
// shared widths, angle table and stage structs for the nadir view angle block
// no dependencies
package nvap_pkg;

  // field and datapath widths
  localparam int SLOPE_W  = 48;
  localparam int COORD_W  = 48;
  localparam int SIZE_W   = 32;
  localparam int ALT_W    = 32;
  localparam int VIEW_W   = 23;
  localparam int PX_W     = 50;
  localparam int PXM_W    = 49;
  localparam int PROD_W   = 97;
  localparam int E_W      = 100;
  localparam int MAG_W    = 97;
  localparam int ROOT_W   = 48;
  localparam int RAD_W    = 96;
  localparam int REM_W    = 50;
  localparam int NORM_W   = 60;
  localparam int XY_W     = 63;
  localparam int Z_W      = 41;
  localparam int VIEWQ_W  = 39;

  // cycles from a slope write until the track scale factor is settled
  localparam int SQRT_DEPTH = 2 + ROOT_W;

  localparam logic [ALT_W-1:0] ALT_RESET  = 32'd179968000;
  localparam logic [Z_W-1:0]   NINETY_Q32 = 41'd386547056640;

  // decimal angle table, twelve fraction digits
  localparam logic [127:0] DEC_UNIT       = 128'd1000000000000;
  localparam logic [63:0]  RAD_TO_DEG_DEC = 64'd57295779513082;
  localparam logic [63:0]  ATAN_DEC [13] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926,
    64'd7125016348902,  64'd3576334374997,  64'd1789910608246,
    64'd895173710211,   64'd447614170861,   64'd223810500369,
    64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142
  };

  // atan(2^-i) in degrees, q.32, evaluated at elaboration
  function automatic logic [Z_W-1:0] stage_angle(input int unsigned idx);
    logic [127:0] v;
    if (idx < 13) begin
      v = {64'd0, ATAN_DEC[idx[3:0]]};
    end else begin
      v = {64'd0, RAD_TO_DEG_DEC};
    end
    v = (v << 32) / DEC_UNIT;
    if (idx >= 13) begin
      v = v >> idx;
    end
    return v[Z_W-1:0];
  endfunction

  // square root digit recurrence state
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

  // distance magnitude waiting for the scale factor
  typedef struct packed {
    logic             valid;
    logic             nod;
    logic [MAG_W-1:0] x;
  } item_t;

  // operand pair in the normalizing shifter
  typedef struct packed {
    logic             valid;
    logic             nod;
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
  } norm_t;

  // vectoring rotation state
  typedef struct packed {
    logic            valid;
    logic            nod;
    logic            zero;
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
  } cordic_t;

endpackage

[rtl/nvap_sqrt_cell.sv]
// one restoring square root step, one root bit per cell
// depends on nvap_pkg
module nvap_sqrt_cell
  import nvap_pkg::*;
(
  input  logic  clk,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // bring down two radicand bits and try the next root bit
  assign rem_sh = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
  assign trial  = {din.root[REM_W-3:0], 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    dout.rem  <= ge ? (rem_sh - trial) : rem_sh;
    dout.root <= {din.root[ROOT_W-2:0], ge};
    dout.rad  <= {din.rad[RAD_W-3:0], 2'b00};
  end

endmodule

[rtl/nvap_norm_cell.sv]
// one conditional right shift of the normalizing shifter
// depends on nvap_pkg
module nvap_norm_cell
  import nvap_pkg::*;
#(
  parameter int SHIFT = 1
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  norm_t din,
  output norm_t dout
);

  logic  big;
  norm_t nxt;

  // shift both operands while the larger one is too long
  assign big = |((din.x | din.y) >> (NORM_W - 1 + SHIFT));

  always_comb begin
    nxt = din;
    if (big) begin
      nxt.x = din.x >> SHIFT;
      nxt.y = din.y >> SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/nvap_cordic_cell.sv]
// one vectoring cordic rotation with a fixed stage angle
// depends on nvap_pkg
module nvap_cordic_cell
  import nvap_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  localparam logic [Z_W-1:0] ANGLE = stage_angle(STAGE);

  logic [XY_W-1:0] dx;
  logic [XY_W-1:0] dy;
  cordic_t         nxt;

  // floor shifts of the cross terms
  assign dx = $unsigned($signed(din.y) >>> STAGE);
  assign dy = $unsigned($signed(din.x) >>> STAGE);

  // rotate toward the x axis
  always_comb begin
    nxt = din;
    if (!din.y[XY_W-1]) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + ANGLE;
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/nadir_view_angle_pixel_unit.sv]
// nadir view angle per raster cell: track distance, scale, cordic atan2
// depends on nvap_pkg, nvap_sqrt_cell, nvap_norm_cell, nvap_cordic_cell
//
// usage
//   input channel: in_valid / in_stall with band_value, min_x, min_y,
//   cell_width, cell_height; a request is taken when in_valid is high and
//   in_stall is low. output channel: out_valid / out_stall with view_angle
//   and is_nodata, one result per request, in order.
//   configuration: apb write of line_slope (0x00), line_offset (0x08) and
//   altitude (0x10), 64-bit data, pready tied high; write only while idle.
// throughput and pipeline
//   one request per cycle sustained while in_stall is low. a request
//   passes six front stages, a delay line that covers the square root
//   chain of the slope scale factor, two scaling stages, six normalizing
//   shifts, the cordic chain and two output stages.
// reset and stall
//   rst clears all valids and loads the register defaults; the square root
//   chain runs freely and settles before any request reaches it. a stalled
//   output holds; one more result lands in a skid register, then in_stall
//   rises and the whole chain holds.
`include "nadir_view_angle_pixel_unit_defines.svh"
module nadir_view_angle_pixel_unit
  import nvap_pkg::*;
#(
  parameter int CORDIC_STAGES   = 24,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          band_value,
  input  logic [COORD_W-1:0]   min_x,
  input  logic [COORD_W-1:0]   min_y,
  input  logic [SIZE_W-1:0]    cell_width,
  input  logic [SIZE_W-1:0]    cell_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VIEW_W-1:0]    view_angle,
  output logic                 is_nodata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int DLY = SQRT_DEPTH + 2 - 6;
  localparam int RSH = 32 - ANGLE_FRAC_BITS;
  localparam logic [VIEWQ_W:0] RND_HALF = {{VIEWQ_W{1'b0}}, 1'b1} << (RSH - 1);

  localparam logic [1:0] REG_SLOPE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_ALT    = 2'd2;

  logic [SLOPE_W-1:0] line_slope;
  logic [COORD_W-1:0] line_offset;
  logic [ALT_W-1:0]   altitude;
  logic               wr;
  logic               en;
  logic [SLOPE_W-1:0] ms;

  // configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_slope  <= '0;
      line_offset <= '0;
      altitude    <= ALT_RESET;
    end else if (wr) begin
      case (paddr[4:3])
        REG_SLOPE:  line_slope  <= pwdata[SLOPE_W-1:0];
        REG_OFFSET: line_offset <= pwdata[COORD_W-1:0];
        REG_ALT:    altitude    <= pwdata[ALT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_SLOPE:  prdata = {16'd0, line_slope};
      REG_OFFSET: prdata = {16'd0, line_offset};
      REG_ALT:    prdata = {32'd0, altitude};
      default:    prdata = 64'd0;
    endcase
  end

  assign ms = line_slope[SLOPE_W-1] ? (~line_slope + 48'd1) : line_slope;

  // free-running scale factor chain: floor(sqrt(2^64 + slope^2))
  logic [47:0] sq_p11;
  logic [47:0] sq_p10;
  logic [47:0] sq_p00;
  sqrt_t       sq [ROOT_W+1];

  always_ff @(posedge clk) begin
    sq_p11 <= ms[47:24] * ms[47:24];
    sq_p10 <= ms[47:24] * ms[23:0];
    sq_p00 <= ms[23:0] * ms[23:0];
    sq[0].rem  <= '0;
    sq[0].root <= '0;
    sq[0].rad  <= {sq_p11, 48'd0} + {23'd0, sq_p10, 25'd0} + {48'd0, sq_p00}
                  + (96'd1 << 64);
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    nvap_sqrt_cell u_cell (.clk(clk), .din(sq[j]), .dout(sq[j+1]));
  end

  // stage 0: capture request
  logic               s0_valid;
  logic               s0_nod;
  logic [COORD_W-1:0] s0_minx;
  logic [COORD_W-1:0] s0_miny;
  logic [SIZE_W-1:0]  s0_w;
  logic [SIZE_W-1:0]  s0_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      s0_nod   <= band_value == 32'd0;
      s0_minx  <= min_x;
      s0_miny  <= min_y;
      s0_w     <= cell_width;
      s0_h     <= cell_height;
    end
  end

  // stage 1: doubled cell center and its x magnitude
  logic [PX_W-1:0]  px2;
  logic [PX_W-1:0]  py2;
  logic [PX_W-1:0]  px_mag;
  logic             s1_valid;
  logic             s1_nod;
  logic             s1_pxneg;
  logic [PXM_W-1:0] s1_pxm;
  logic [PX_W-1:0]  s1_py2;

  assign px2    = {s0_minx[COORD_W-1], s0_minx, 1'b0} + {18'd0, s0_w};
  assign py2    = {s0_miny[COORD_W-1], s0_miny, 1'b0} + {18'd0, s0_h};
  assign px_mag = px2[PX_W-1] ? (~px2 + 50'd1) : px2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
      s1_nod   <= s0_nod;
      s1_pxneg <= px2[PX_W-1];
      s1_pxm   <= px_mag[PXM_W-1:0];
      s1_py2   <= py2;
    end
  end

  // stage 2: partial products of slope times x
  logic            s2_valid;
  logic            s2_nod;
  logic            s2_neg;
  logic [48:0]     s2_pp11;
  logic [47:0]     s2_pp10;
  logic [48:0]     s2_pp01;
  logic [47:0]     s2_pp00;
  logic [PX_W-1:0] s2_py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_nod   <= s1_nod;
      s2_neg   <= line_slope[SLOPE_W-1] ^ s1_pxneg;
      s2_pp11  <= ms[47:24] * s1_pxm[48:24];
      s2_pp10  <= ms[47:24] * s1_pxm[23:0];
      s2_pp01  <= ms[23:0] * s1_pxm[48:24];
      s2_pp00  <= ms[23:0] * s1_pxm[23:0];
      s2_py2   <= s1_py2;
    end
  end

  // stage 3: sum of partial products
  logic              s3_valid;
  logic              s3_nod;
  logic              s3_neg;
  logic [PROD_W-1:0] s3_prod;
  logic [PX_W-1:0]   s3_py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_nod   <= s2_nod;
      s3_neg   <= s2_neg;
      s3_prod  <= {s2_pp11, 48'd0} + {25'd0, s2_pp10, 24'd0}
                  + {24'd0, s2_pp01, 24'd0} + {49'd0, s2_pp00};
      s3_py2   <= s2_py2;
    end
  end

  // stage 4: signed track error slope*x + offset - y, q.49
  logic [E_W-1:0] prod_s;
  logic [E_W-1:0] off_ext;
  logic [E_W-1:0] py_ext;
  logic           s4_valid;
  logic           s4_nod;
  logic [E_W-1:0] s4_e;

  assign prod_s  = s3_neg ? (~{3'd0, s3_prod} + 100'd1) : {3'd0, s3_prod};
  assign off_ext = {{19{line_offset[COORD_W-1]}}, line_offset, 33'd0};
  assign py_ext  = {{18{s3_py2[PX_W-1]}}, s3_py2, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
      s4_nod   <= s3_nod;
      s4_e     <= prod_s + off_ext - py_ext;
    end
  end

  // stage 5: error magnitude
  logic [E_W-1:0] e_mag;
  item_t          s5;

  assign e_mag = s4_e[E_W-1] ? (~s4_e + 100'd1) : s4_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.valid <= 1'b0;
    end else if (en) begin
      s5.valid <= s4_valid;
      s5.nod   <= s4_nod;
      s5.x     <= e_mag[MAG_W-1:0];
    end
  end

  // delay line until the scale factor of the current slope is settled
  item_t dly [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DLY; j++) begin
        dly[j].valid <= 1'b0;
      end
    end else if (en) begin
      dly[0] <= s5;
      for (int j = 1; j < DLY; j++) begin
        dly[j] <= dly[j-1];
      end
    end
  end

  // scaling: altitude times scale factor, two partial products
  logic [ROOT_W-1:0] scale;
  item_t             y1;
  logic [55:0]       y1_ya;
  logic [55:0]       y1_yb;
  logic [79:0]       y_prod;
  norm_t             nm [7];

  assign scale = sq[ROOT_W].root;

  always_ff @(posedge clk) begin
    if (rst) begin
      y1.valid <= 1'b0;
    end else if (en) begin
      y1    <= dly[DLY-1];
      y1_ya <= altitude * scale[47:24];
      y1_yb <= altitude * scale[23:0];
    end
  end

  assign y_prod = {y1_ya, 24'd0} + {24'd0, y1_yb};

  always_ff @(posedge clk) begin
    if (rst) begin
      nm[0].valid <= 1'b0;
    end else if (en) begin
      nm[0].valid <= y1.valid;
      nm[0].nod   <= y1.nod;
      nm[0].x     <= y1.x;
      nm[0].y     <= {8'd0, y_prod, 9'd0};
    end
  end

  // normalizing shifter: both operands below 2^60
  for (genvar k = 0; k < 6; k++) begin : g_norm
    nvap_norm_cell #(.SHIFT(32 >> k)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(nm[k]), .dout(nm[k+1])
    );
  end

  // cordic chain
  cordic_t cd [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cd[0].valid <= 1'b0;
    end else if (en) begin
      cd[0].valid <= nm[6].valid;
      cd[0].nod   <= nm[6].nod;
      cd[0].zero  <= (nm[6].x == '0) && (nm[6].y == '0);
      cd[0].x     <= {3'd0, nm[6].x[NORM_W-1:0]};
      cd[0].y     <= {3'd0, nm[6].y[NORM_W-1:0]};
      cd[0].z     <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    nvap_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(cd[i]), .dout(cd[i+1])
    );
  end

  // clamp to 0..90 degrees and take the complement
  cordic_t            cd_last;
  logic [Z_W-1:0]     zc;
  logic [Z_W-1:0]     view_full;
  logic               fin_valid;
  logic               fin_nod;
  logic [VIEWQ_W-1:0] fin_view;

  assign cd_last = cd[CORDIC_STAGES];

  always_comb begin
    if (cd_last.zero || cd_last.z[Z_W-1]) begin
      zc = '0;
    end else if (cd_last.z > NINETY_Q32) begin
      zc = NINETY_Q32;
    end else begin
      zc = cd_last.z;
    end
  end

  assign view_full = NINETY_Q32 - zc;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= cd_last.valid;
      fin_nod   <= cd_last.nod;
      fin_view  <= view_full[VIEWQ_W-1:0];
    end
  end

  // round half up to the output fraction
  logic [VIEWQ_W:0]  round_sum;
  logic [VIEWQ_W:0]  rounded;
  logic [VIEW_W-1:0] ld_angle;

  assign round_sum = {1'b0, fin_view} + RND_HALF;
  assign rounded   = round_sum >> RSH;
  assign ld_angle  = fin_nod ? '0 : rounded[VIEW_W-1:0];

  // output register with skid stage
  logic              ov;
  logic              sv;
  logic              take;
  logic [VIEW_W-1:0] od_angle;
  logic              od_nod;
  logic [VIEW_W-1:0] sd_angle;
  logic              sd_nod;

  assign en   = !sv;
  assign take = ov && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) begin
        od_angle <= sd_angle;
        od_nod   <= sd_nod;
        sv       <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!ov || take) begin
        od_angle <= ld_angle;
        od_nod   <= fin_nod;
        ov       <= 1'b1;
      end else begin
        sd_angle <= ld_angle;
        sd_nod   <= fin_nod;
        sv       <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  assign in_stall   = sv;
  assign out_valid  = ov;
  assign view_angle = od_angle;
  assign is_nodata  = od_nod;

  // checks
  `NVAP_ASSERT_SAME(a_skid_needs_out, sv, ov, "skid holds a result with output empty")
  `NVAP_ASSERT_NEXT(a_skid_drains, sv && !out_stall, !sv && ov, "skid did not drain")
  `NVAP_ASSERT_NEXT(a_free_out_loads, fin_valid && !sv && !ov, ov && !sv, "result bypassed out")
  `NVAP_ASSERT_SAME(a_nodata_zero, out_valid && is_nodata, view_angle == '0, "nodata angle set")

endmodule
